// ===== rtl/core/sat_pkg.sv =====
// Shared types and constants for the section address translator.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package sat_pkg;

  localparam int ADDR_W  = 32;
  localparam int IDX_IN_W = 4;
  localparam int CNT_IN_W = 5;
  localparam int OP_W     = 2;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_V2F   = 2'd1,
    OP_F2V   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_XLATE
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } bk_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] vbase;
    logic [ADDR_W-1:0] vlen;
    logic [ADDR_W-1:0] rbase;
    logic [ADDR_W-1:0] rlen;
  } entry_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                to_file;
    logic                wr_en;
    logic [IDX_IN_W-1:0] entry_index;
    entry_t              entry;
    logic [ADDR_W-1:0]   lookup_address;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sat_if.sv =====
// Channel interfaces of the section address translator: request, result and
// configuration write. Depends on sat_pkg for widths.
`default_nettype none

interface sat_in_if;
  logic                          valid;
  logic                          ready;
  logic [sat_pkg::OP_W-1:0]      operation;
  logic [sat_pkg::IDX_IN_W-1:0]  entry_index;
  logic [sat_pkg::ADDR_W-1:0]    virtual_base;
  logic [sat_pkg::ADDR_W-1:0]    virtual_length;
  logic [sat_pkg::ADDR_W-1:0]    raw_base;
  logic [sat_pkg::ADDR_W-1:0]    raw_length;
  logic [sat_pkg::ADDR_W-1:0]    lookup_address;

  modport source (output valid, operation, entry_index, virtual_base, virtual_length,
                  raw_base, raw_length, lookup_address, input ready);
  modport sink   (input valid, operation, entry_index, virtual_base, virtual_length,
                  raw_base, raw_length, lookup_address, output ready);
endinterface

interface sat_out_if;
  logic                       valid;
  logic                       ready;
  logic [sat_pkg::ADDR_W-1:0] translated_address;
  logic                       hit;

  modport source (output valid, translated_address, hit, input ready);
  modport sink   (input valid, translated_address, hit, output ready);
endinterface

interface sat_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sat_pkg::CNT_IN_W-1:0] section_count;

  modport source (output valid, section_count, input ready);
  modport sink   (input valid, section_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/section_address_translator.sv =====
// Top level of the section address translator: configuration register and
// the front end, command queue and back end. Depends on sat_pkg, sat_if.sv,
// sat_front, sat_queue and sat_back.
//
//   channel   dir  handshake      carries
//   in_ch     in   valid/ready    operation, entry and lookup address
//   out_ch    out  valid/ready    translated_address, hit
//   cfg_ch    in   valid/ready    section_count (always ready)
//
// Write and unused operations are answered directly from idle; a translation
// examines k entries, k being those up to the first match (at most
// min(section_count, MAX_SECTIONS)), one entry per cycle through the single
// read port of the section table. A two-item queue decouples request intake.
// Reset clears the count, queue and control; the section table is not reset.
// A full result register stalls the back end; a full queue stalls in_ch.
`default_nettype none

module section_address_translator #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sat_in_if.sink      in_ch,
  sat_out_if.source   out_ch,
  sat_cfg_if.sink     cfg_ch
);

  logic [sat_pkg::CNT_IN_W-1:0] section_count_r, section_count_nxt;
  logic                         push_valid, push_ready;
  sat_pkg::cmd_t                push_cmd;
  logic                         q_valid, q_pop;
  sat_pkg::cmd_t                q_cmd;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    section_count_nxt = section_count_r;
    if (cfg_ch.valid) begin
      section_count_nxt = cfg_ch.section_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_count_r <= '0;
    end else begin
      section_count_r <= section_count_nxt;
    end
  end

  sat_front #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  sat_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  sat_back #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .section_count (section_count_r),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sat_front.sv =====
// Front end: takes request items and decodes them into queue commands.
// Depends on sat_pkg and sat_in_if.
`default_nettype none

module sat_front #(
  parameter int MAX_SECTIONS = 16
) (
  sat_in_if.sink        in_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output sat_pkg::cmd_t push_cmd
);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_cmd.kind           = sat_pkg::CMD_NOP;
    push_cmd.to_file        = 1'b0;
    push_cmd.wr_en          = 1'b0;
    push_cmd.entry_index    = in_ch.entry_index;
    push_cmd.entry.vbase    = in_ch.virtual_base;
    push_cmd.entry.vlen     = in_ch.virtual_length;
    push_cmd.entry.rbase    = in_ch.raw_base;
    push_cmd.entry.rlen     = in_ch.raw_length;
    push_cmd.lookup_address = in_ch.lookup_address;
    unique case (in_ch.operation)
      sat_pkg::OP_WRITE: begin
        push_cmd.kind  = sat_pkg::CMD_WRITE;
        // drop writes beyond the table
        push_cmd.wr_en = (32'(in_ch.entry_index) < 32'(MAX_SECTIONS));
      end
      sat_pkg::OP_V2F: begin
        push_cmd.kind    = sat_pkg::CMD_XLATE;
        push_cmd.to_file = 1'b1;
      end
      sat_pkg::OP_F2V: begin
        push_cmd.kind    = sat_pkg::CMD_XLATE;
        push_cmd.to_file = 1'b0;
      end
      default: begin
        push_cmd.kind = sat_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/sat_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on sat_pkg.
`default_nettype none

module sat_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  sat_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output sat_pkg::cmd_t pop_cmd
);

  sat_pkg::cmd_t                q_mem_r [sat_pkg::Q_DEPTH];
  logic [sat_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [sat_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [sat_pkg::Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign push_ready = (cnt_r != sat_pkg::Q_CNT_W'(sat_pkg::Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = q_mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + sat_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - sat_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sat_pkg::Q_CNT_W'(sat_pkg::Q_DEPTH))
    else $error("queue fill beyond depth");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sat_back.sv =====
// Back end: section table memory, sequential range search and result register.
// Depends on sat_pkg and sat_out_if.
`default_nettype none

module sat_back #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [sat_pkg::CNT_IN_W-1:0]   section_count,
  input  logic                           q_valid,
  input  sat_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  sat_out_if.source                      out_ch
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CW    = $clog2(MAX_SECTIONS + 1);
  localparam int AW    = sat_pkg::ADDR_W;

  sat_pkg::entry_t     sect_mem [MAX_SECTIONS];
  sat_pkg::entry_t     rd_data_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;

  sat_pkg::bk_state_t  state_r, state_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic                to_file_r, to_file_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [AW-1:0]       out_addr_r, out_addr_nxt;
  logic                out_hit_r, out_hit_nxt;

  logic [CW-1:0]       limit;
  logic                out_free;
  logic                start_scan;
  logic [AW-1:0]       from_base, from_len, to_base;
  logic [AW:0]         diff;
  logic                hit_now, last, scan_done;
  logic [AW-1:0]       xlat;

  always_comb begin
    if (32'(section_count) > 32'(MAX_SECTIONS)) begin
      limit = CW'(MAX_SECTIONS);
    end else begin
      limit = CW'(section_count);
    end
  end

  assign out_free   = !out_valid_r || out_ch.ready;
  assign start_scan = (q_cmd.kind == sat_pkg::CMD_XLATE) && (limit != '0);

  // range test on the entry fetched last cycle
  always_comb begin
    from_base = to_file_r ? rd_data_r.vbase : rd_data_r.rbase;
    from_len  = to_file_r ? rd_data_r.vlen  : rd_data_r.rlen;
    to_base   = to_file_r ? rd_data_r.rbase : rd_data_r.vbase;
    diff      = {1'b0, addr_r} - {1'b0, from_base};
    hit_now   = !diff[AW] && (diff[AW-1:0] < from_len);
    xlat      = diff[AW-1:0] + to_base;
    last      = ((ptr_r + CW'(1)) == limit);
    scan_done = hit_now || last;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sat_pkg::BK_IDLE: begin
        if (q_valid && start_scan) begin
          state_nxt = sat_pkg::BK_SCAN;
        end
      end
      sat_pkg::BK_SCAN: begin
        if (scan_done && out_free) begin
          state_nxt = sat_pkg::BK_IDLE;
        end
      end
      default: state_nxt = sat_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    ptr_nxt      = ptr_r;
    addr_nxt     = addr_r;
    to_file_nxt  = to_file_r;
    out_addr_nxt = out_addr_r;
    out_hit_nxt  = out_hit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      sat_pkg::BK_IDLE: begin
        ptr_nxt = '0;
        if (q_valid && start_scan) begin
          q_pop       = 1'b1;
          addr_nxt    = q_cmd.lookup_address;
          to_file_nxt = q_cmd.to_file;
        end else if (q_valid && out_free) begin
          // write, unused operation or empty search: answer at once
          q_pop         = 1'b1;
          mem_we        = (q_cmd.kind == sat_pkg::CMD_WRITE) && q_cmd.wr_en;
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_hit_nxt   = 1'b0;
        end
      end
      sat_pkg::BK_SCAN: begin
        if (!scan_done) begin
          ptr_nxt = ptr_r + CW'(1);
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_now;
          out_addr_nxt  = hit_now ? xlat : '0;
        end
      end
      default: ;
    endcase
  end

  // hold the fetched entry while stalled on the result side
  assign rd_addr = ptr_nxt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sect_mem[IDX_W'(q_cmd.entry_index)] <= q_cmd.entry;
    end
    rd_data_r <= sect_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sat_pkg::BK_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    to_file_r  <= to_file_nxt;
    out_addr_r <= out_addr_nxt;
    out_hit_r  <= out_hit_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.translated_address = out_addr_r;
  assign out_ch.hit                = out_hit_r;

`ifndef ASSERT_OFF
  a_ptr_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sat_pkg::BK_SCAN) |-> (ptr_r < limit))
    else $error("scan pointer beyond searched entries");
`endif
`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_addr_r == '0))
    else $error("miss result carries a non-zero address");
`endif
`ifndef ASSERT_OFF
  a_scan_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sat_pkg::BK_SCAN && scan_done && out_free)
      |=> (state_r == sat_pkg::BK_IDLE && out_valid_r))
    else $error("finished search did not deliver a result");
`endif

endmodule

`default_nettype wire
